FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter: widths, codes, dabble step.
package sitda_pkg;

  localparam int VALUE_WIDTH = 32;
  // Decimal digits in the largest magnitude, 2^(VALUE_WIDTH-1).
  localparam int NUM_DIGITS  = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int STEP_W      = $clog2(VALUE_WIDTH);
  localparam int DIG_W       = $clog2(NUM_DIGITS);
  localparam int CHAR_W      = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(57);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef logic [BCD_W-1:0] bcd_t;

  // Add 3 to every digit of 5 or more, ahead of the next left shift.
  function automatic bcd_t dabble_adjust(input bcd_t bcd);
    bcd_t res;
    res = bcd;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII converter, top level.
//
// Converts one signed VALUE_WIDTH-bit integer into its decimal text, one ASCII
// character per output transaction, most significant first, with a leading
// minus sign for negative values, no leading zeros, and last set on the final
// digit. A value is loaded, then shifted into BCD bit by bit through the
// shift-add-3 unit, then the BCD digits are walked, with the sign sent first
// for a negative number; an output stall holds the walk until the output
// slot frees. The input is stalled from acceptance until the last character
// is loaded into the output register.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [sitda_pkg::VALUE_WIDTH-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sitda_pkg::CHAR_W-1:0]        ascii_char_o,
  output logic                                last_o
);
  import sitda_pkg::*;

  state_e                   state_q, state_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [DIG_W-1:0]         dig_q, dig_d;
  logic                     neg_q, neg_d;
  logic                     started_q, started_d;
  logic [VALUE_WIDTH-1:0]   mag_q, mag_d;
  bcd_t                     bcd_q, bcd_d;
  bcd_t                     bcd_adj;
  logic                     out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]        char_q, char_d;
  logic                     last_q, last_d;
  logic                     slot_free;
  logic                     in_accept;
  logic [3:0]               top_digit;
  logic                     dig_last;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign bcd_adj   = dabble_adjust(bcd_q);
  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign dig_last  = (dig_q == '0);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    dig_d       = dig_q;
    neg_d       = neg_q;
    started_d   = started_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    char_d      = char_q;
    last_d      = last_q;
    // Drop the output once taken unless something new is loaded below.
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          neg_d     = value_i[VALUE_WIDTH-1];
          mag_d     = value_i[VALUE_WIDTH-1] ? (~value_i + 1'b1) : value_i;
          bcd_d     = '0;
          step_d    = STEP_W'(VALUE_WIDTH - 1);
          dig_d     = DIG_W'(NUM_DIGITS - 1);
          started_d = 1'b0;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
        mag_d = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        if (step_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (neg_q) begin
            char_d      = CHAR_MINUS;
            last_d      = 1'b0;
            out_valid_d = 1'b1;
            neg_d       = 1'b0;
          end else begin
            // Skip leading zeros, but always send the final digit.
            if (top_digit != 4'd0 || started_q || dig_last) begin
              char_d      = CHAR_ZERO + {2'b00, top_digit};
              last_d      = dig_last;
              out_valid_d = 1'b1;
              started_d   = 1'b1;
            end
            bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
            if (dig_last) begin
              state_d = ST_IDLE;
            end else begin
              dig_d = dig_q - 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      dig_q       <= '0;
      neg_q       <= 1'b0;
      started_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      dig_q       <= dig_d;
      neg_q       <= neg_d;
      started_q   <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_o       = last_q;

  `ASSERT_CLK(a_accept_starts_conv, in_valid_i && !in_stall_o |=> state_q == ST_CONV,
    "accepted transaction did not start conversion")
  `ASSERT_CLK(a_conv_ends_in_emit, state_q == ST_CONV && step_q == '0 |=> state_q == ST_EMIT,
    "conversion did not hand over to emission")
  `ASSERT_CLK(a_char_range, out_valid_o |-> ascii_char_o == CHAR_MINUS ||
    (ascii_char_o >= CHAR_ZERO && ascii_char_o <= CHAR_NINE), "output character out of range")
  `ASSERT_CLK(a_minus_not_last, !(out_valid_o && last_o && ascii_char_o == CHAR_MINUS),
    "minus sign flagged as last character")

endmodule
